@@ hw/rtl/natpmt_pkg.sv @@
// NAT port mapping table: shared types, codes and defaults.
// No dependencies; used by the top level.
package natpmt_pkg;

  localparam int DEF_PORTS_PER_TABLE = 1024;
  localparam int DEF_NUM_TABLES      = 16;
  localparam int DEF_NUM_HOSTS       = 256;

  localparam logic [15:0] PORT_BASE_RST    = 16'd10000;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd60;

  localparam logic [1:0] CFG_PORT_BASE    = 2'd0;
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd1;

  typedef enum logic [1:0] {
    FUNC_OUTBOUND = 2'd0,
    FUNC_INBOUND  = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_NOP      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  inner_host;
    logic [15:0] port_number;
    logic        proto;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] translated_port;
    logic [7:0]  orig_host;
    logic [15:0] orig_port;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HOST_RD, ST_SETUP,
    ST_BS, ST_BS_SLOT, ST_BS_CMP,
    ST_IN_DIV, ST_IN_WR,
    ST_INS_RD, ST_INS_GET, ST_SH_CHK, ST_SH_WR, ST_INS_FIN,
    ST_SC_ORD, ST_SC_SLOT, ST_SC_CMP,
    ST_UP_CHK, ST_UP_SLOT, ST_UP_CMP, ST_UP_SW,
    ST_DN_CHK, ST_DN_SLOT, ST_DN_CMP, ST_DN_SW,
    ST_DONE, ST_RESP
  } state_t;

endpackage

@@ hw/rtl/natpmt_ram.sv @@
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module natpmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata <= mem_r[addr];
    end
  end

endmodule

@@ hw/rtl/nat_port_mapping_table_unit.sv @@
// NAT port mapping table, top level.
// Depends on natpmt_pkg and natpmt_ram.

// Port translation table for NAT. Each inner host is given one of NUM_TABLES
// tables round-robin, evicting the previous owner; each table has a TCP and a
// UDP set of PORTS_PER_TABLE slots, slot s of table t translating to outer
// port port_base + t*PORTS_PER_TABLE + s (mod 2^16). Slot contents (source
// port, last-used second) sit in one RAM, the per-set sorted order in a
// second RAM; both are single ported with a registered read, and every step of
// the search, insert and reorder is one read or write of them. After reset the
// block clears every set (source ports to zero, order to identity) with
// in_ready low; cfg writes are taken throughout. One beat is handled at a
// time. A tick or ignored beat is handled in the idle state; an inbound
// lookup finds the table number by repeated subtraction; an outbound lookup
// binary-searches the sorted order of the set and, on a miss, inserts by
// shifting order entries up or, when the set is full, scans for a stale slot
// and then moves it to its sorted place step by step. The slot RAM port is
// the limiting resource. A finished result is held in the output register
// and the next beat is accepted while it waits.
module nat_port_mapping_table_unit #(
  parameter int PORTS_PER_TABLE = natpmt_pkg::DEF_PORTS_PER_TABLE,
  parameter int NUM_TABLES      = natpmt_pkg::DEF_NUM_TABLES,
  parameter int NUM_HOSTS       = natpmt_pkg::DEF_NUM_HOSTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  natpmt_pkg::in_beat_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output natpmt_pkg::out_beat_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int PPT  = PORTS_PER_TABLE;
  localparam int SETS = 2 * NUM_TABLES;
  localparam int PW   = $clog2(PPT);                 // slot / position index
  localparam int CW   = $clog2(PPT + 1);             // count, holds PPT
  localparam int TW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int SW   = TW + 1;                      // set index
  localparam int AW   = $clog2(SETS * PPT);          // slot / order RAM address
  localparam int HIW  = $clog2(NUM_HOSTS);
  localparam int OW   = $clog2(NUM_TABLES * PPT);    // inbound offset
  localparam int SLW  = 48;                          // {source port, last used}

  natpmt_pkg::state_t state_r, state_nxt;

  logic [15:0] port_base_r, idle_timeout_r;
  logic [31:0] clock_r;

  // small tables in flops
  logic            host_valid_r  [NUM_HOSTS];
  logic [TW-1:0]   next_table_r;
  logic            owner_valid_r [NUM_TABLES];
  logic [7:0]      owner_host_r  [NUM_TABLES];
  logic [CW-1:0]   entry_count_r [SETS];

  // per-beat working registers
  natpmt_pkg::in_beat_t  req_r, req_nxt;
  natpmt_pkg::out_beat_t res_r, res_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [PW-1:0] slot_r, slot_nxt, oth_r, oth_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [SW-1:0] clr_set_r, clr_set_nxt;
  logic [PW-1:0] clr_pos_r, clr_pos_nxt;

  logic                  out_valid_r, out_valid_nxt;
  natpmt_pkg::out_beat_t out_data_r, out_data_nxt;

  // side-effect strobes for the flop tables
  logic claim_en, cnt_inc_en, tick_en;

  // RAM ports
  logic           host_we;
  logic [HIW-1:0] host_addr;
  logic [TW-1:0]  host_rdata;
  logic           ord_we, slot_we;
  logic [CW-1:0]  ord_pos;
  logic [PW-1:0]  ord_wdata, ord_rdata, slot_sel;
  logic [SLW-1:0] slot_wdata, slot_rdata;
  logic [AW-1:0]  ord_addr, slot_addr;
  logic [SW-1:0]  set_c, mem_set;
  logic [15:0]    rd_src;
  logic [31:0]    rd_used;

  logic [31:0] in_off32;
  logic [15:0] outer_port;
  logic [CW-1:0] mid;

  assign set_c    = {t_r, req_r.proto};
  assign mem_set  = (state_r == natpmt_pkg::ST_CLEAR) ? clr_set_r : set_c;
  assign ord_addr = AW'(mem_set) * AW'(PPT) + AW'(ord_pos);
  assign slot_addr = AW'(mem_set) * AW'(PPT) + AW'(slot_sel);
  assign rd_src   = slot_rdata[47:32];
  assign rd_used  = slot_rdata[31:0];
  assign mid      = CW'((({1'b0, lo_r}) + ({1'b0, hi_r})) >> 1);
  assign outer_port = 16'(32'(port_base_r) + 32'(t_r) * 32'(PPT) + 32'(slot_r));
  assign in_off32 = 32'(in_data.port_number) - 32'(port_base_r);

  assign in_ready  = (state_r == natpmt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  natpmt_ram #(.WIDTH(TW), .DEPTH(NUM_HOSTS)) u_host_ram (
    .clk(clk), .we(host_we), .addr(host_addr), .wdata(next_table_r), .rdata(host_rdata)
  );
  natpmt_ram #(.WIDTH(PW), .DEPTH(SETS * PPT)) u_order_ram (
    .clk(clk), .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata)
  );
  natpmt_ram #(.WIDTH(SLW), .DEPTH(SETS * PPT)) u_slot_ram (
    .clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    oth_nxt       = oth_r;
    off_nxt       = off_r;
    clr_set_nxt   = clr_set_r;
    clr_pos_nxt   = clr_pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    claim_en      = 1'b0;
    cnt_inc_en    = 1'b0;
    tick_en       = 1'b0;
    host_we       = 1'b0;
    host_addr     = req_r.inner_host[HIW-1:0];
    ord_we        = 1'b0;
    ord_pos       = pos_r;
    ord_wdata     = slot_r;
    slot_we       = 1'b0;
    slot_sel      = slot_r;
    slot_wdata    = {req_r.port_number, clock_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      natpmt_pkg::ST_CLEAR: begin
        // source ports to zero, order to identity
        ord_we      = 1'b1;
        ord_pos     = CW'(clr_pos_r);
        ord_wdata   = clr_pos_r;
        slot_we     = 1'b1;
        slot_sel    = clr_pos_r;
        slot_wdata  = '0;
        if (clr_pos_r == PW'(PPT - 1)) begin
          clr_pos_nxt = '0;
          clr_set_nxt = clr_set_r + 1'b1;
          if (clr_set_r == SW'(SETS - 1)) begin
            state_nxt = natpmt_pkg::ST_IDLE;
          end
        end else begin
          clr_pos_nxt = clr_pos_r + 1'b1;
        end
      end
      natpmt_pkg::ST_IDLE: begin
        host_addr = in_data.inner_host[HIW-1:0];
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          case (in_data.func)
            natpmt_pkg::FUNC_TICK: tick_en = 1'b1;
            natpmt_pkg::FUNC_OUTBOUND: begin
              if ({1'b0, in_data.inner_host} < 9'(NUM_HOSTS)) begin
                state_nxt = natpmt_pkg::ST_HOST_RD;
              end
            end
            natpmt_pkg::FUNC_INBOUND: begin
              if (in_data.port_number < port_base_r ||
                  in_off32 >= 32'(NUM_TABLES * PPT)) begin
                res_nxt.status = natpmt_pkg::STAT_RANGE;
                state_nxt      = natpmt_pkg::ST_RESP;
              end else begin
                off_nxt   = OW'(in_off32);
                t_nxt     = '0;
                state_nxt = natpmt_pkg::ST_IN_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      natpmt_pkg::ST_IN_DIV: begin
        if ({1'b0, off_r} >= (OW + 1)'(PPT)) begin
          off_nxt = off_r - OW'(PPT);
          t_nxt   = t_r + 1'b1;
        end else begin
          slot_nxt  = off_r[PW-1:0];
          slot_sel  = off_r[PW-1:0];
          state_nxt = natpmt_pkg::ST_IN_WR;
        end
      end
      natpmt_pkg::ST_IN_WR: begin
        slot_we          = 1'b1;
        slot_wdata       = {rd_src, clock_r};
        res_nxt.orig_host = owner_host_r[t_r];
        res_nxt.orig_port = rd_src;
        state_nxt        = natpmt_pkg::ST_RESP;
      end
      natpmt_pkg::ST_HOST_RD: begin
        if (host_valid_r[req_r.inner_host[HIW-1:0]]) begin
          t_nxt = host_rdata;
        end else begin
          claim_en = 1'b1;
          host_we  = 1'b1;
          t_nxt    = next_table_r;
        end
        state_nxt = natpmt_pkg::ST_SETUP;
      end
      natpmt_pkg::ST_SETUP: begin
        cnt_nxt   = entry_count_r[set_c];
        lo_nxt    = '0;
        hi_nxt    = entry_count_r[set_c];
        state_nxt = natpmt_pkg::ST_BS;
      end
      natpmt_pkg::ST_BS: begin
        if (lo_r < hi_r) begin
          ord_pos   = mid;
          pos_nxt   = mid;
          state_nxt = natpmt_pkg::ST_BS_SLOT;
        end else if (cnt_r < CW'(PPT)) begin
          state_nxt = natpmt_pkg::ST_INS_RD;
        end else begin
          pos_nxt   = '0;
          state_nxt = natpmt_pkg::ST_SC_ORD;
        end
      end
      natpmt_pkg::ST_BS_SLOT: begin
        slot_nxt  = ord_rdata;
        slot_sel  = ord_rdata;
        state_nxt = natpmt_pkg::ST_BS_CMP;
      end
      natpmt_pkg::ST_BS_CMP: begin
        if (rd_src == req_r.port_number) begin
          slot_we   = 1'b1;
          state_nxt = natpmt_pkg::ST_DONE;
        end else if (rd_src < req_r.port_number) begin
          lo_nxt    = pos_r + 1'b1;
          state_nxt = natpmt_pkg::ST_BS;
        end else begin
          hi_nxt    = pos_r;
          state_nxt = natpmt_pkg::ST_BS;
        end
      end
      natpmt_pkg::ST_INS_RD: begin
        ord_pos   = cnt_r;
        state_nxt = natpmt_pkg::ST_INS_GET;
      end
      natpmt_pkg::ST_INS_GET: begin
        slot_nxt  = ord_rdata;
        pos_nxt   = cnt_r;
        state_nxt = natpmt_pkg::ST_SH_CHK;
      end
      natpmt_pkg::ST_SH_CHK: begin
        if (pos_r > lo_r) begin
          ord_pos   = pos_r - 1'b1;
          state_nxt = natpmt_pkg::ST_SH_WR;
        end else begin
          ord_we    = 1'b1;
          ord_pos   = lo_r;
          state_nxt = natpmt_pkg::ST_INS_FIN;
        end
      end
      natpmt_pkg::ST_SH_WR: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rdata;
        pos_nxt   = pos_r - 1'b1;
        state_nxt = natpmt_pkg::ST_SH_CHK;
      end
      natpmt_pkg::ST_INS_FIN: begin
        slot_we    = 1'b1;
        cnt_inc_en = 1'b1;
        state_nxt  = natpmt_pkg::ST_DONE;
      end
      natpmt_pkg::ST_SC_ORD: begin
        if (pos_r == CW'(PPT)) begin
          res_nxt.status = natpmt_pkg::STAT_FULL;
          state_nxt      = natpmt_pkg::ST_RESP;
        end else begin
          state_nxt = natpmt_pkg::ST_SC_SLOT;
        end
      end
      natpmt_pkg::ST_SC_SLOT: begin
        slot_nxt  = ord_rdata;
        slot_sel  = ord_rdata;
        state_nxt = natpmt_pkg::ST_SC_CMP;
      end
      natpmt_pkg::ST_SC_CMP: begin
        if ((clock_r - rd_used) >= {16'd0, idle_timeout_r}) begin
          slot_we   = 1'b1;
          state_nxt = natpmt_pkg::ST_UP_CHK;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = natpmt_pkg::ST_SC_ORD;
        end
      end
      natpmt_pkg::ST_UP_CHK: begin
        if ((CW + 1)'(pos_r) + 1'b1 < (CW + 1)'(PPT)) begin
          ord_pos   = pos_r + 1'b1;
          state_nxt = natpmt_pkg::ST_UP_SLOT;
        end else begin
          state_nxt = natpmt_pkg::ST_DN_CHK;
        end
      end
      natpmt_pkg::ST_UP_SLOT: begin
        oth_nxt   = ord_rdata;
        slot_sel  = ord_rdata;
        state_nxt = natpmt_pkg::ST_UP_CMP;
      end
      natpmt_pkg::ST_UP_CMP: begin
        if (req_r.port_number > rd_src) begin
          ord_we    = 1'b1;
          ord_wdata = oth_r;
          state_nxt = natpmt_pkg::ST_UP_SW;
        end else begin
          state_nxt = natpmt_pkg::ST_DN_CHK;
        end
      end
      natpmt_pkg::ST_UP_SW: begin
        ord_we    = 1'b1;
        ord_pos   = pos_r + 1'b1;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = natpmt_pkg::ST_UP_CHK;
      end
      natpmt_pkg::ST_DN_CHK: begin
        if (pos_r != '0) begin
          ord_pos   = pos_r - 1'b1;
          state_nxt = natpmt_pkg::ST_DN_SLOT;
        end else begin
          state_nxt = natpmt_pkg::ST_DONE;
        end
      end
      natpmt_pkg::ST_DN_SLOT: begin
        oth_nxt   = ord_rdata;
        slot_sel  = ord_rdata;
        state_nxt = natpmt_pkg::ST_DN_CMP;
      end
      natpmt_pkg::ST_DN_CMP: begin
        if (req_r.port_number < rd_src) begin
          ord_we    = 1'b1;
          ord_wdata = oth_r;
          state_nxt = natpmt_pkg::ST_DN_SW;
        end else begin
          state_nxt = natpmt_pkg::ST_DONE;
        end
      end
      natpmt_pkg::ST_DN_SW: begin
        ord_we    = 1'b1;
        ord_pos   = pos_r - 1'b1;
        pos_nxt   = pos_r - 1'b1;
        state_nxt = natpmt_pkg::ST_DN_CHK;
      end
      natpmt_pkg::ST_DONE: begin
        res_nxt.translated_port = outer_port;
        state_nxt               = natpmt_pkg::ST_RESP;
      end
      natpmt_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = natpmt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = natpmt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= natpmt_pkg::ST_CLEAR;
      out_valid_r    <= 1'b0;
      clr_set_r      <= '0;
      clr_pos_r      <= '0;
      clock_r        <= '0;
      next_table_r   <= '0;
      port_base_r    <= natpmt_pkg::PORT_BASE_RST;
      idle_timeout_r <= natpmt_pkg::IDLE_TIMEOUT_RST;
      for (int h = 0; h < NUM_HOSTS; h++) begin
        host_valid_r[h] <= 1'b0;
      end
      for (int t = 0; t < NUM_TABLES; t++) begin
        owner_valid_r[t] <= 1'b0;
        owner_host_r[t]  <= '0;
      end
      for (int s = 0; s < SETS; s++) begin
        entry_count_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_set_r   <= clr_set_nxt;
      clr_pos_r   <= clr_pos_nxt;
      if (tick_en) begin
        clock_r <= clock_r + 32'd1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == natpmt_pkg::CFG_PORT_BASE) begin
          port_base_r <= cfg_data;
        end else if (cfg_index == natpmt_pkg::CFG_IDLE_TIMEOUT) begin
          idle_timeout_r <= cfg_data;
        end
      end
      if (claim_en) begin
        // evict the previous owner, then hand the table to this host
        next_table_r <= (next_table_r == TW'(NUM_TABLES - 1)) ? '0 : next_table_r + 1'b1;
        entry_count_r[{next_table_r, 1'b0}] <= '0;
        entry_count_r[{next_table_r, 1'b1}] <= '0;
        if (owner_valid_r[next_table_r]) begin
          host_valid_r[owner_host_r[next_table_r][HIW-1:0]] <= 1'b0;
        end
        owner_valid_r[next_table_r] <= 1'b1;
        owner_host_r[next_table_r]  <= req_r.inner_host;
        host_valid_r[req_r.inner_host[HIW-1:0]] <= 1'b1;
      end
      if (cnt_inc_en) begin
        entry_count_r[set_c] <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    t_r        <= t_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    pos_r      <= pos_nxt;
    slot_r     <= slot_nxt;
    oth_r      <= oth_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

  // a set never holds more slots than it has
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == natpmt_pkg::ST_SETUP |-> entry_count_r[set_c] <= CW'(PPT))
    else $error("entry count above set size");

  // binary search compares only inside a non-empty window
  a_bs_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == natpmt_pkg::ST_BS_CMP |-> lo_r < hi_r && pos_r < hi_r)
    else $error("binary search probe outside window");

  // a tick beat advances the seconds clock by exactly one
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == natpmt_pkg::FUNC_TICK
    |=> clock_r == $past(clock_r) + 32'd1)
    else $error("seconds clock did not advance on tick");

endmodule
